FILE: rtl/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB pixel converter.
// Used by hsv2rgb_front, hsv2rgb_rdiv, hsv_pixel_to_rgb and the testbench; depends on nothing.
`default_nettype none

package hsv2rgb_pkg;

    localparam int unsigned CH_W        = 8;
    localparam int unsigned PROD_W      = 16;
    localparam int unsigned NUM_W       = 24;
    localparam int unsigned SIX_W       = 11;
    localparam int unsigned SEC_W       = 3;
    localparam int unsigned RECIP_W     = 17;
    localparam int unsigned RECIP_SHIFT = 32;
    localparam int unsigned NUM_STAGES  = 6;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [CH_W-1:0]    CH_MAX    = 8'd255;
    localparam logic [PROD_W-1:0]  DEN2      = 16'd65025;
    localparam logic [NUM_W-1:0]   HALF_DEN2 = 24'd32512;
    // floor(2^32 / 65025): quotient estimate is exact or one low
    localparam logic [RECIP_W-1:0] RECIP     = 17'd66051;

    localparam logic [SEC_W-1:0] SEC_0 = 3'd0;
    localparam logic [SEC_W-1:0] SEC_1 = 3'd1;
    localparam logic [SEC_W-1:0] SEC_2 = 3'd2;
    localparam logic [SEC_W-1:0] SEC_3 = 3'd3;
    localparam logic [SEC_W-1:0] SEC_4 = 3'd4;
    localparam logic [SEC_W-1:0] SEC_5 = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_IS_BG = 2'd0,
        CFG_BG_RED     = 2'd1,
        CFG_BG_GREEN   = 2'd2,
        CFG_BG_BLUE    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_HSV  = 2'd0,
        KIND_GREY = 2'd1,
        KIND_BG   = 2'd2
    } pix_kind_t;

    typedef struct packed {
        pix_kind_t             kind;
        logic [SEC_W-1:0]      sector;
        logic [CH_W-1:0]       value;
        logic                  last;
    } pix_tag_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } front_en_t;

    typedef struct packed {
        logic s4;
        logic s5;
    } rdiv_en_t;

endpackage

`default_nettype wire

FILE: rtl/hsv2rgb_front.sv
// Front three stages: hue sector and fraction, saturation products, and the
// rounded numerators over 65025 for the p, q and t terms. Uses hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_front (
    input  wire                                   aclk,
    input  hsv2rgb_pkg::front_en_t                en,
    input  wire  [hsv2rgb_pkg::CH_W-1:0]          hue,
    input  wire  [hsv2rgb_pkg::CH_W-1:0]          sat,
    input  wire  [hsv2rgb_pkg::CH_W-1:0]          val,
    input  wire                                   last,
    input  wire                                   zero_is_bg,
    output logic [hsv2rgb_pkg::NUM_W-1:0]         num_p,
    output logic [hsv2rgb_pkg::NUM_W-1:0]         num_q,
    output logic [hsv2rgb_pkg::NUM_W-1:0]         num_t,
    output hsv2rgb_pkg::pix_tag_t                 tag
);

    // stage 1
    logic [hsv2rgb_pkg::CH_W-1:0]   h_wrap;
    logic [hsv2rgb_pkg::SIX_W-1:0]  six;
    logic [hsv2rgb_pkg::SIX_W-1:0]  sec_base;
    logic [hsv2rgb_pkg::SEC_W-1:0]  sector;
    hsv2rgb_pkg::pix_kind_t         kind;
    hsv2rgb_pkg::pix_tag_t          tag1_reg, tag1_next;
    logic [hsv2rgb_pkg::CH_W-1:0]   frac1_reg, frac1_next;
    logic [hsv2rgb_pkg::CH_W-1:0]   sat1_reg;

    // stage 2
    hsv2rgb_pkg::pix_tag_t          tag2_reg;
    logic [hsv2rgb_pkg::PROD_W-1:0] sf2_reg, sf2_next;
    logic [hsv2rgb_pkg::PROD_W-1:0] sfc2_reg, sfc2_next;
    logic [hsv2rgb_pkg::PROD_W-1:0] vs2_reg, vs2_next;

    // stage 3
    hsv2rgb_pkg::pix_tag_t          tag3_reg;
    logic [hsv2rgb_pkg::NUM_W-1:0]  nump3_reg, nump3_next;
    logic [hsv2rgb_pkg::NUM_W-1:0]  numq3_reg, numq3_next;
    logic [hsv2rgb_pkg::NUM_W-1:0]  numt3_reg, numt3_next;

    always_comb begin
        h_wrap = (hue == hsv2rgb_pkg::CH_MAX) ? '0 : hue;
        six    = (hsv2rgb_pkg::SIX_W'(h_wrap) << 2) + (hsv2rgb_pkg::SIX_W'(h_wrap) << 1);
        priority if (six >= hsv2rgb_pkg::SIX_W'(1275)) begin
            sector = hsv2rgb_pkg::SEC_5;
        end else if (six >= hsv2rgb_pkg::SIX_W'(1020)) begin
            sector = hsv2rgb_pkg::SEC_4;
        end else if (six >= hsv2rgb_pkg::SIX_W'(765)) begin
            sector = hsv2rgb_pkg::SEC_3;
        end else if (six >= hsv2rgb_pkg::SIX_W'(510)) begin
            sector = hsv2rgb_pkg::SEC_2;
        end else if (six >= hsv2rgb_pkg::SIX_W'(255)) begin
            sector = hsv2rgb_pkg::SEC_1;
        end else begin
            sector = hsv2rgb_pkg::SEC_0;
        end
        sec_base   = hsv2rgb_pkg::SIX_W'(sector) * hsv2rgb_pkg::SIX_W'(hsv2rgb_pkg::CH_MAX);
        frac1_next = hsv2rgb_pkg::CH_W'(six - sec_base);

        // background test looks at the raw hue, so hue 255 never matches
        priority if (zero_is_bg && (hue == '0) && (sat == '0) && (val == '0)) begin
            kind = hsv2rgb_pkg::KIND_BG;
        end else if (sat != '0) begin
            kind = hsv2rgb_pkg::KIND_HSV;
        end else begin
            kind = hsv2rgb_pkg::KIND_GREY;
        end
        tag1_next.kind   = kind;
        tag1_next.sector = sector;
        tag1_next.value  = val;
        tag1_next.last   = last;
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            tag1_reg  <= tag1_next;
            frac1_reg <= frac1_next;
            sat1_reg  <= sat;
        end
    end

    always_comb begin
        sf2_next  = hsv2rgb_pkg::PROD_W'(sat1_reg) * hsv2rgb_pkg::PROD_W'(frac1_reg);
        sfc2_next = hsv2rgb_pkg::PROD_W'(sat1_reg)
                  * hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::CH_MAX - frac1_reg);
        vs2_next  = hsv2rgb_pkg::PROD_W'(tag1_reg.value)
                  * hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::CH_MAX - sat1_reg);
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            tag2_reg <= tag1_reg;
            sf2_reg  <= sf2_next;
            sfc2_reg <= sfc2_next;
            vs2_reg  <= vs2_next;
        end
    end

    // scale p up to the 65025 denominator so all three terms use the same divider module
    always_comb begin
        numq3_next = hsv2rgb_pkg::NUM_W'(tag2_reg.value)
                   * hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::DEN2 - sf2_reg)
                   + hsv2rgb_pkg::HALF_DEN2;
        numt3_next = hsv2rgb_pkg::NUM_W'(tag2_reg.value)
                   * hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::DEN2 - sfc2_reg)
                   + hsv2rgb_pkg::HALF_DEN2;
        nump3_next = hsv2rgb_pkg::NUM_W'(vs2_reg) * hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::CH_MAX)
                   + hsv2rgb_pkg::HALF_DEN2;
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            tag3_reg  <= tag2_reg;
            nump3_reg <= nump3_next;
            numq3_reg <= numq3_next;
            numt3_reg <= numt3_next;
        end
    end

    assign num_p = nump3_reg;
    assign num_q = numq3_reg;
    assign num_t = numt3_reg;
    assign tag   = tag3_reg;

endmodule

`default_nettype wire

FILE: rtl/hsv2rgb_rdiv.sv
// Two-stage divider by 65025: reciprocal multiply, then one correction step.
// Uses hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_rdiv (
    input  wire                              aclk,
    input  hsv2rgb_pkg::rdiv_en_t            en,
    input  wire  [hsv2rgb_pkg::NUM_W-1:0]    num,
    output logic [hsv2rgb_pkg::CH_W-1:0]     quo
);

    localparam int unsigned MUL_W = hsv2rgb_pkg::NUM_W + hsv2rgb_pkg::RECIP_W;

    logic [MUL_W-1:0]              prod;
    logic [hsv2rgb_pkg::CH_W-1:0]  q0_reg, q0_next;
    logic [hsv2rgb_pkg::NUM_W-1:0] num4_reg;
    logic [hsv2rgb_pkg::NUM_W-1:0] rem;
    logic [hsv2rgb_pkg::CH_W-1:0]  quo_reg, quo_next;

    always_comb begin
        prod    = MUL_W'(num) * MUL_W'(hsv2rgb_pkg::RECIP);
        q0_next = prod[hsv2rgb_pkg::RECIP_SHIFT +: hsv2rgb_pkg::CH_W];
    end

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            q0_reg   <= q0_next;
            num4_reg <= num;
        end
    end

    // estimate is exact or one low: bump it when a full divisor remains
    always_comb begin
        rem      = num4_reg - hsv2rgb_pkg::NUM_W'(q0_reg) * hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::DEN2);
        quo_next = (rem >= hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::DEN2))
                 ? q0_reg + hsv2rgb_pkg::CH_W'(1) : q0_reg;
    end

    always_ff @(posedge aclk) begin
        if (en.s5) begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/hsv_pixel_to_rgb.sv
// Top level of the HSV to RGB pixel converter: handshake, config registers,
// channel select. Uses hsv2rgb_pkg, hsv2rgb_front and hsv2rgb_rdiv.
//
// Usage:
//   Input stream s_*: one HSV pixel per transfer, s_tdata = hue, saturation,
//   value (bits 7:0, 15:8, 23:16), s_tlast marks the last pixel of an image.
//   Output stream m_*: one RGB pixel per input pixel, in order, m_tdata =
//   red, green, blue (bits 7:0, 15:8, 23:16), m_tlast copies s_tlast.
//   Config port: cfg_we with cfg_index 0 = zero-is-background enable,
//   1..3 = background red, green, blue. Write only while no pixel is in
//   flight.
//   Pipeline: a pixel accepted at a clock edge passes through six register
//   stages (sector, products, numerators, two divider stages, channel
//   select; the first loads at the accepting edge) before it is on m_*.
//   Throughput: one pixel per clock while m_tready is high.
//   Stall: when m_tready is low the output holds and empty stages upstream
//   keep filling; s_tready drops only once every stage holds a pixel.
//   Reset: aresetn low clears all stage valid bits, sets zero-is-background
//   to 1 and the background colour to black.
`default_nettype none

module hsv_pixel_to_rgb (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // config write port
    input  wire                                  cfg_we,
    input  wire  [hsv2rgb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [hsv2rgb_pkg::CH_W-1:0]         cfg_wdata,
    // input stream
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [23:0]                          s_tdata,   // hue_byte, saturation_byte, value_byte
    input  wire                                  s_tlast,   // end_of_image
    // output stream
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [23:0]                          m_tdata,   // red_out, green_out, blue_out
    output logic                                 m_tlast    // last_of_image
);

    localparam int unsigned NS = hsv2rgb_pkg::NUM_STAGES;

    logic                          zero_is_bg_reg;
    logic [hsv2rgb_pkg::CH_W-1:0]  bg_red_reg;
    logic [hsv2rgb_pkg::CH_W-1:0]  bg_green_reg;
    logic [hsv2rgb_pkg::CH_W-1:0]  bg_blue_reg;

    logic [NS:1]                   valid_reg, valid_next;
    logic [NS:1]                   stage_ready;

    hsv2rgb_pkg::front_en_t        front_en;
    hsv2rgb_pkg::rdiv_en_t         rdiv_en;

    logic [hsv2rgb_pkg::NUM_W-1:0] num_p, num_q, num_t;
    logic [hsv2rgb_pkg::CH_W-1:0]  p_byte, q_byte, t_byte;
    hsv2rgb_pkg::pix_tag_t         tag3, tag4_reg, tag5_reg;

    logic [hsv2rgb_pkg::CH_W-1:0]  red_reg, red_next;
    logic [hsv2rgb_pkg::CH_W-1:0]  green_reg, green_next;
    logic [hsv2rgb_pkg::CH_W-1:0]  blue_reg, blue_next;
    logic                          last_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_is_bg_reg <= 1'b1;
            bg_red_reg     <= '0;
            bg_green_reg   <= '0;
            bg_blue_reg    <= '0;
        end else if (cfg_we) begin
            unique case (hsv2rgb_pkg::cfg_idx_t'(cfg_index))
                hsv2rgb_pkg::CFG_ZERO_IS_BG: zero_is_bg_reg <= cfg_wdata[0];
                hsv2rgb_pkg::CFG_BG_RED:     bg_red_reg     <= cfg_wdata;
                hsv2rgb_pkg::CFG_BG_GREEN:   bg_green_reg   <= cfg_wdata;
                hsv2rgb_pkg::CFG_BG_BLUE:    bg_blue_reg    <= cfg_wdata;
            endcase
        end
    end

    // a stage may load when it is empty or its contents move on
    always_comb begin
        stage_ready[NS] = ~valid_reg[NS] | m_tready;
        for (int k = NS - 1; k >= 1; k--) begin
            stage_ready[k] = ~valid_reg[k] | stage_ready[k+1];
        end
        valid_next = valid_reg;
        if (stage_ready[1]) begin
            valid_next[1] = s_tvalid;
        end
        for (int k = 2; k <= NS; k++) begin
            if (stage_ready[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign front_en.s1 = stage_ready[1];
    assign front_en.s2 = stage_ready[2];
    assign front_en.s3 = stage_ready[3];
    assign rdiv_en.s4  = stage_ready[4];
    assign rdiv_en.s5  = stage_ready[5];

    hsv2rgb_front u_front (
        .aclk       (aclk),
        .en         (front_en),
        .hue        (s_tdata[7:0]),
        .sat        (s_tdata[15:8]),
        .val        (s_tdata[23:16]),
        .last       (s_tlast),
        .zero_is_bg (zero_is_bg_reg),
        .num_p      (num_p),
        .num_q      (num_q),
        .num_t      (num_t),
        .tag        (tag3)
    );

    hsv2rgb_rdiv u_rdiv_p (.aclk(aclk), .en(rdiv_en), .num(num_p), .quo(p_byte));
    hsv2rgb_rdiv u_rdiv_q (.aclk(aclk), .en(rdiv_en), .num(num_q), .quo(q_byte));
    hsv2rgb_rdiv u_rdiv_t (.aclk(aclk), .en(rdiv_en), .num(num_t), .quo(t_byte));

    always_ff @(posedge aclk) begin
        if (rdiv_en.s4) begin
            tag4_reg <= tag3;
        end
        if (rdiv_en.s5) begin
            tag5_reg <= tag4_reg;
        end
    end

    // channel select by pixel kind and sector
    always_comb begin
        red_next   = tag5_reg.value;
        green_next = tag5_reg.value;
        blue_next  = tag5_reg.value;
        unique case (tag5_reg.kind)
            hsv2rgb_pkg::KIND_BG: begin
                red_next   = bg_red_reg;
                green_next = bg_green_reg;
                blue_next  = bg_blue_reg;
            end
            hsv2rgb_pkg::KIND_HSV: begin
                unique case (tag5_reg.sector)
                    hsv2rgb_pkg::SEC_0: begin
                        green_next = t_byte;
                        blue_next  = p_byte;
                    end
                    hsv2rgb_pkg::SEC_1: begin
                        red_next   = q_byte;
                        blue_next  = p_byte;
                    end
                    hsv2rgb_pkg::SEC_2: begin
                        red_next   = p_byte;
                        blue_next  = t_byte;
                    end
                    hsv2rgb_pkg::SEC_3: begin
                        red_next   = p_byte;
                        green_next = q_byte;
                    end
                    hsv2rgb_pkg::SEC_4: begin
                        red_next   = t_byte;
                        green_next = p_byte;
                    end
                    default: begin
                        green_next = p_byte;
                        blue_next  = q_byte;
                    end
                endcase
            end
            default: begin
                red_next   = tag5_reg.value;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[NS]) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            last_reg  <= tag5_reg.last;
        end
    end

    assign s_tready = stage_ready[1];
    assign m_tvalid = valid_reg[NS];
    assign m_tdata  = {blue_reg, green_reg, red_reg};
    assign m_tlast  = last_reg;

    // input backpressure only when the whole pipe is full behind a stalled output
    a_ready_full : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&valid_reg) && !m_tready)
        else $error("s_tready low while a pipeline stage is empty");

    a_accept_enters : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> valid_reg[1])
        else $error("accepted pixel did not enter the first stage");

    a_count_kept : assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> ($countones(valid_reg) == $countones($past(valid_reg))
            + int'($past(s_tvalid && s_tready)) - int'($past(m_tvalid && m_tready))))
        else $error("pixel lost or duplicated in the pipeline");

    a_stall_full : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && (&valid_reg) |-> !s_tready)
        else $error("input taken while pipeline is full and stalled");

endmodule

`default_nettype wire

FILE: sim/hsv_pixel_to_rgb_tb.sv
// Self-checking testbench for hsv_pixel_to_rgb: a directed table and then random
// HSV pixel streams over several background settings, with random stalls on both sides.
// Depends on hsv2rgb_pkg and the hsv_pixel_to_rgb RTL only.
`timescale 1ns / 100ps

module hsv_pixel_to_rgb_tb;

    localparam int unsigned FULL     = 255;
    localparam int unsigned FULL_SQ  = 65025;
    localparam int NUM_DIRECTED      = 20;
    localparam int RANDOM_PER_PHASE  = 108;
    localparam int NUM_PHASES        = 4;
    localparam int DRAIN_CYCLES      = 20;
    localparam int MAX_REPORTS       = 10;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } rgb_pixel_t;

    // typed = 1: the row carries its own expected color
    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
        logic       last;
        logic       typed;
        logic [7:0] exp_red;
        logic [7:0] exp_green;
        logic [7:0] exp_blue;
    } hsv_row_t;

    localparam hsv_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // all-zero pixel turns into the background color (black after reset)
        '{8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 8'd0,   8'd0,   8'd0},
        // hue 255 with zero saturation and value is not background
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b1, 8'd0,   8'd0,   8'd0},
        // zero saturation: grey at value
        '{8'd0,   8'd0,   8'd255, 1'b0, 1'b1, 8'd255, 8'd255, 8'd255},
        '{8'd200, 8'd0,   8'd77,  1'b1, 1'b1, 8'd77,  8'd77,  8'd77},
        // primaries at full saturation and value
        '{8'd0,   8'd255, 8'd255, 1'b0, 1'b1, 8'd255, 8'd0,   8'd0},
        '{8'd85,  8'd255, 8'd255, 1'b0, 1'b1, 8'd0,   8'd255, 8'd0},
        '{8'd170, 8'd255, 8'd255, 1'b0, 1'b1, 8'd0,   8'd0,   8'd255},
        // hue 255 wraps to red
        '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 8'd255, 8'd0,   8'd0},
        // zero value is black whatever the hue
        '{8'd0,   8'd255, 8'd0,   1'b0, 1'b1, 8'd0,   8'd0,   8'd0},
        '{8'd255, 8'd255, 8'd0,   1'b0, 1'b1, 8'd0,   8'd0,   8'd0},
        // sector edges
        '{8'd42,  8'd255, 8'd255, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd43,  8'd255, 8'd128, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd127, 8'd1,   8'd255, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd128, 8'd255, 8'd255, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd212, 8'd128, 8'd200, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd213, 8'd255, 8'd255, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd254, 8'd255, 8'd255, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd1,   8'd1,   8'd1,   1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd171, 8'd254, 8'd255, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd86,  8'd170, 8'd90,  1'b1, 1'b0, 8'd0,   8'd0,   8'd0}
    };

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_we    = 1'b0;
    hsv2rgb_pkg::cfg_idx_t cfg_index = hsv2rgb_pkg::CFG_ZERO_IS_BG;
    logic [7:0] cfg_wdata = 8'd0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [23:0] s_tdata  = 24'd0;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic       m_tlast;

    // shadow copy of the configuration registers
    logic       bg_enable = 1'b1;
    logic [7:0] bg_red    = 8'd0;
    logic [7:0] bg_green  = 8'd0;
    logic [7:0] bg_blue   = 8'd0;

    // expectation source for the pixel currently on the input bus
    logic       row_typed  = 1'b0;
    rgb_pixel_t row_expect = '0;

    rgb_pixel_t pending_rgb[$];
    int         mismatch_count = 0;
    int         burst_left     = 0;
    int         ready_hold     = 0;

    hsv_pixel_to_rgb DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // round(v * (65025 - s*frac) / 65025); odd denominator, so no ties
    function automatic logic [7:0] fade_term(int unsigned v, int unsigned s, int unsigned frac);
        return 8'((v * (FULL_SQ - s * frac) + FULL_SQ / 2) / FULL_SQ);
    endfunction

    function automatic rgb_pixel_t convert_pixel(logic [7:0] hue, logic [7:0] sat,
                                                 logic [7:0] val, logic last);
        int unsigned      six;
        int unsigned      frac;
        logic [hsv2rgb_pkg::SEC_W-1:0] sector;
        logic [7:0]       p;
        logic [7:0]       q;
        logic [7:0]       t;
        rgb_pixel_t       px;
        px = '{red: val, green: val, blue: val, last: last};
        if (bg_enable && hue == 8'd0 && sat == 8'd0 && val == 8'd0) begin
            px.red   = bg_red;
            px.green = bg_green;
            px.blue  = bg_blue;
        end else if (sat != 8'd0) begin
            six    = (hue == 8'd255) ? 0 : 6 * int'(hue);
            sector = hsv2rgb_pkg::SEC_W'(six / FULL);
            frac   = six % FULL;
            p = 8'((int'(val) * (FULL - int'(sat)) + FULL / 2) / FULL);
            q = fade_term(32'(val), 32'(sat), frac);
            t = fade_term(32'(val), 32'(sat), FULL - frac);
            case (sector)
                hsv2rgb_pkg::SEC_0: begin px.red = val; px.green = t;   px.blue = p;   end
                hsv2rgb_pkg::SEC_1: begin px.red = q;   px.green = val; px.blue = p;   end
                hsv2rgb_pkg::SEC_2: begin px.red = p;   px.green = val; px.blue = t;   end
                hsv2rgb_pkg::SEC_3: begin px.red = p;   px.green = q;   px.blue = val; end
                hsv2rgb_pkg::SEC_4: begin px.red = t;   px.green = p;   px.blue = val; end
                default: begin px.red = val; px.green = p; px.blue = q;   end
            endcase
        end
        return px;
    endfunction

    // Record accepted inputs first, then check accepted outputs, in one process.
    always @(posedge aclk) begin : check_output
        rgb_pixel_t got;
        rgb_pixel_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pending_rgb.push_back(row_typed ? row_expect :
                    convert_pixel(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tlast));
            end
            if (m_tvalid && m_tready) begin
                got = '{red: m_tdata[7:0], green: m_tdata[15:8], blue: m_tdata[23:16],
                        last: m_tlast};
                if (pending_rgb.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected pixel r=%0d g=%0d b=%0d last=%0b",
                                 $realtime, got.red, got.green, got.blue, got.last);
                end else begin
                    want = pending_rgb.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"%0t: pixel mismatch, expected r=%0d g=%0d b=%0d ",
                                      "last=%0b, got r=%0d g=%0d b=%0d last=%0b"},
                                     $realtime, want.red, want.green, want.blue, want.last,
                                     got.red, got.green, got.blue, got.last);
                    end
                end
            end
        end
    end

    // Output backpressure: short random runs, now and then a long stall or a long open stretch.
    always @(negedge aclk) begin : drive_ready
        int pick;
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(0, 6);
            end else if (pick < 85) begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end else if (pick < 93) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(20, 60);
            end else begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(10, 40);
            end
        end
    end

    // Called and returns at a falling edge.
    task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                              input logic [7:0] val, input logic last,
                              input logic typed, input rgb_pixel_t expected);
        int gap;
        int roll;
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                burst_left = $urandom_range(20, 60);
            else if (roll >= 60 && roll < 93)
                gap = $urandom_range(1, 3);
            else if (roll >= 93)
                gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= {val, sat, hue};
        s_tlast    <= last;
        row_typed  <= typed;
        row_expect <= expected;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_random();
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
        int         pick;
        hue  = 8'($urandom_range(0, 255));
        sat  = 8'($urandom_range(0, 255));
        val  = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            hue = 8'd0; sat = 8'd0; val = 8'd0;
        end else if (pick < 12) begin
            hue = 8'd255;
            if (pick < 10) begin sat = 8'd0; val = 8'd0; end
        end else if (pick < 18) begin
            sat = 8'd0;
        end else if (pick < 22) begin
            val = 8'd0;
        end
        send_pixel(hue, sat, val, $urandom_range(0, 15) == 0, 1'b0, '0);
    endtask

    // Hold the input idle until every expected pixel has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_rgb.size() != 0);
    endtask

    task automatic write_config(input logic [7:0] enable_byte, input logic [7:0] red,
                                input logic [7:0] green, input logic [7:0] blue);
        cfg_we    <= 1'b1;
        cfg_index <= hsv2rgb_pkg::CFG_ZERO_IS_BG;
        cfg_wdata <= enable_byte;
        @(negedge aclk);
        cfg_index <= hsv2rgb_pkg::CFG_BG_RED;
        cfg_wdata <= red;
        @(negedge aclk);
        cfg_index <= hsv2rgb_pkg::CFG_BG_GREEN;
        cfg_wdata <= green;
        @(negedge aclk);
        cfg_index <= hsv2rgb_pkg::CFG_BG_BLUE;
        cfg_wdata <= blue;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        // only bit 0 of the enable register is kept
        bg_enable = enable_byte[0];
        bg_red    = red;
        bg_green  = green;
        bg_blue   = blue;
    endtask

    initial begin : stimulus
        hsv_row_t row;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            row = DIRECTED_ROWS[i];
            send_pixel(row.hue, row.sat, row.val, row.last, row.typed,
                       '{red: row.exp_red, green: row.exp_green, blue: row.exp_blue,
                         last: row.last});
        end
        wait_drained();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: write_config(8'h01, 8'hFF, 8'hFF, 8'hFF);
                1: write_config(8'hFE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)));
                2: write_config(8'hFF, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)));
                default: write_config(8'h00, 8'h00, 8'h00, 8'h00);
            endcase
            repeat (RANDOM_PER_PHASE) begin
                if ($urandom_range(0, 63) == 0)
                    wait_drained();
                send_random();
            end
            wait_drained();
        end

        // let any stray output show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_rgb.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_front.sv
rtl/hsv2rgb_rdiv.sv
rtl/hsv_pixel_to_rgb.sv
sim/hsv_pixel_to_rgb_tb.sv
